[sv/mmmac_pkg.sv]
// shared constants, types and helpers for the matrix multiply engine
`timescale 1ns / 1ps
package mmmac_pkg;

  localparam int MAX_DIM      = 8;
  localparam int ELEM_BITS    = 16;
  localparam int IDX_BITS     = $clog2(MAX_DIM);
  localparam int ADDR_BITS    = $clog2(MAX_DIM * MAX_DIM);
  localparam int CFG_BITS     = 4;
  localparam int POS_BITS     = 3;
  localparam int CMD_BITS     = 2;
  localparam int REG_IDX_BITS = 2;
  localparam int SUM_BITS     = 35;
  localparam int PROD_BITS    = 2 * ELEM_BITS;
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_BITS   = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS   = $clog2(Q_DEPTH + 1);

  localparam logic [CMD_BITS-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_COMPUTE = 2'd2;

  localparam logic [REG_IDX_BITS-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_INNER_LEN = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_COLS_B    = 2'd2;

  typedef logic signed [ELEM_BITS-1:0] elem_t;
  typedef logic signed [PROD_BITS-1:0] prod_t;
  typedef logic signed [SUM_BITS-1:0]  sum_t;

  typedef enum logic [1:0] {
    OP_LOAD_A,
    OP_LOAD_B,
    OP_COMPUTE
  } op_kind_t;

  typedef struct packed {
    op_kind_t               kind;
    logic [ADDR_BITS-1:0]   addr;
    elem_t                  value;
  } op_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] rows_a;
    logic [CFG_BITS-1:0] inner_len;
    logic [CFG_BITS-1:0] cols_b;
  } dims_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NEXT,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  // highest loop index for a dimension register; zero acts as one, big values saturate
  function automatic logic [IDX_BITS-1:0] last_index(logic [CFG_BITS-1:0] v);
    if (v == '0) return '0;
    if (int'(v) > MAX_DIM) return IDX_BITS'(MAX_DIM - 1);
    return IDX_BITS'(v - 1'b1);
  endfunction

endpackage

[sv/mmmac_front.sv]
// front end: accepts input beats, drops no-op commands, forms queue entries
`timescale 1ns / 1ps
module mmmac_front import mmmac_pkg::*; (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_BITS-1:0]   command,
  input  logic [POS_BITS-1:0]   elem_row,
  input  logic [POS_BITS-1:0]   elem_col,
  input  elem_t                 elem_value,
  input  logic                  q_full,
  output logic                  push,
  output op_t                   push_op
);

  logic accept;
  logic in_range;
  logic keep;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign in_range = (int'(elem_row) < MAX_DIM) && (int'(elem_col) < MAX_DIM);

  always_comb begin
    push_op.kind  = OP_COMPUTE;
    push_op.addr  = ADDR_BITS'(int'(elem_row) * MAX_DIM + int'(elem_col));
    push_op.value = elem_value;
    keep          = 1'b0;
    case (command)
      CMD_LOAD_A: begin
        push_op.kind = OP_LOAD_A;
        keep         = in_range;
      end
      CMD_LOAD_B: begin
        push_op.kind = OP_LOAD_B;
        keep         = in_range;
      end
      CMD_COMPUTE: begin
        push_op.kind = OP_COMPUTE;
        keep         = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push = accept && keep;

endmodule

[sv/mmmac_queue.sv]
// short fifo between the front end and the compute back end
`timescale 1ns / 1ps
module mmmac_queue import mmmac_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  output logic q_valid,
  output op_t  q_op,
  input  logic pop
);

  op_t                   entries [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr;
  logic [Q_PTR_BITS-1:0] rd_ptr;
  logic [Q_CNT_BITS-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == Q_CNT_BITS'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_op    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/mmmac_back.sv]
// back end: element stores, loop sequencer, mac pipeline and output register
`timescale 1ns / 1ps
module mmmac_back import mmmac_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  dims_t               dims,
  input  logic                q_valid,
  input  op_t                 q_op,
  output logic                q_pop,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [POS_BITS-1:0] out_row,
  output logic [POS_BITS-1:0] out_col,
  output sum_t                out_sum,
  output logic                out_last
);

  elem_t mem_a [MAX_DIM * MAX_DIM];
  elem_t mem_b [MAX_DIM * MAX_DIM];

  state_t               state, state_next;
  logic [IDX_BITS-1:0]  i, i_next;
  logic [IDX_BITS-1:0]  j, j_next;
  logic [IDX_BITS-1:0]  k, k_next;
  logic [IDX_BITS-1:0]  last_i, last_j, last_k;
  logic                 issue, wr_a, wr_b, start, land;
  logic [ADDR_BITS-1:0] rd_addr_a, rd_addr_b;

  elem_t rd_a, rd_b;
  logic  p1_valid, p1_first, p1_last;
  prod_t prod;
  logic  p2_valid, p2_first, p2_last;
  sum_t  acc, acc_next;

  assign land      = p2_valid && p2_last;
  assign rd_addr_a = ADDR_BITS'(int'(i) * MAX_DIM + int'(k));
  assign rd_addr_b = ADDR_BITS'(int'(k) * MAX_DIM + int'(j));
  assign acc_next  = p2_first ? sum_t'(prod) : acc + sum_t'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    q_pop      = 1'b0;
    issue      = 1'b0;
    wr_a       = 1'b0;
    wr_b       = 1'b0;
    start      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_op.kind)
            OP_LOAD_A: wr_a = 1'b1;
            OP_LOAD_B: wr_b = 1'b1;
            OP_COMPUTE: begin
              start      = 1'b1;
              i_next     = '0;
              j_next     = '0;
              state_next = ST_NEXT;
            end
            default: ;
          endcase
        end
      end
      // an entry starts only when the output register is free by the time it lands
      ST_NEXT: begin
        if (!out_valid || !out_stall) begin
          k_next     = '0;
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        issue = 1'b1;
        if (k == last_k) begin
          state_next = ST_DRAIN;
        end else begin
          k_next = k + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (land) begin
          if (i == last_i && j == last_j) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_NEXT;
            if (j == last_j) begin
              j_next = '0;
              i_next = i + 1'b1;
            end else begin
              j_next = j + 1'b1;
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    i <= i_next;
    j <= j_next;
    k <= k_next;
    if (start) begin
      last_i <= last_index(dims.rows_a);
      last_j <= last_index(dims.cols_b);
      last_k <= last_index(dims.inner_len);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[q_op.addr] <= q_op.value;
    end
    rd_a <= mem_a[rd_addr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[q_op.addr] <= q_op.value;
    end
    rd_b <= mem_b[rd_addr_b];
  end

  // mac pipeline: read, multiply, accumulate
  always_ff @(posedge clk) begin
    p1_first <= (k == '0);
    p1_last  <= (k == last_k);
    prod     <= rd_a * rd_b;
    p2_first <= p1_first;
    p2_last  <= p1_last;
    if (p2_valid) begin
      acc <= acc_next;
    end
    if (land) begin
      out_sum  <= acc_next;
      out_row  <= POS_BITS'(i);
      out_col  <= POS_BITS'(j);
      out_last <= (i == last_i) && (j == last_j);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p1_valid <= issue;
      p2_valid <= p1_valid;
      if (land) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/matrix_multiply_mac.sv]
// load beats go to the element stores; a compute beat emits rows*cols result beats
// each result entry goes through a start check, which waits while the output register
// is held by a stall, then one mac issue per inner index, then the multiplier and the
// adder after the registered store read
// reset clears control state and sets the dimension registers to one
// element stores are not cleared; entries read before being written give no defined sum
`timescale 1ns / 1ps
module matrix_multiply_mac import mmmac_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [REG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CMD_BITS-1:0]     command,
  input  logic [POS_BITS-1:0]     elem_row,
  input  logic [POS_BITS-1:0]     elem_col,
  input  elem_t                   elem_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [POS_BITS-1:0]     out_row,
  output logic [POS_BITS-1:0]     out_col,
  output sum_t                    out_sum,
  output logic                    out_last
);

  dims_t dims;
  logic  push, q_full, q_valid, q_pop;
  op_t   push_op, q_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims.rows_a    <= CFG_BITS'(1);
      dims.inner_len <= CFG_BITS'(1);
      dims.cols_b    <= CFG_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_A:    dims.rows_a    <= cfg_data;
        REG_INNER_LEN: dims.inner_len <= cfg_data;
        REG_COLS_B:    dims.cols_b    <= cfg_data;
        default: ;
      endcase
    end
  end

  mmmac_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .elem_row   (elem_row),
    .elem_col   (elem_col),
    .elem_value (elem_value),
    .q_full     (q_full),
    .push       (push),
    .push_op    (push_op)
  );

  mmmac_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .q_valid (q_valid),
    .q_op    (q_op),
    .pop     (q_pop)
  );

  mmmac_back u_back (
    .clk       (clk),
    .rst       (rst),
    .dims      (dims),
    .q_valid   (q_valid),
    .q_op      (q_op),
    .q_pop     (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_sum   (out_sum),
    .out_last  (out_last)
  );

endmodule
